/* rtl/dshr_pkg.sv */
// ============================================================================
// dshr_pkg: shared definitions for the daily step history block
// Widths, history depth, calendar constants and the day-number result type.
// ============================================================================
package dshr_pkg;

  // Number of daily totals kept; slot k holds the total of k days ago.
  localparam int HISTORY_DAYS = 7;
  localparam int IDX_W        = $clog2(HISTORY_DAYS);
  localparam int CNT_W        = $clog2(HISTORY_DAYS + 1);

  localparam int STEP_W = 32;
  localparam int DATE_W = 25;
  localparam int DAYS_W = 20;

  // Calendar limits and constants.
  localparam int YEAR_MIN = 2000;
  localparam int YEAR_MAX = 2100;
  localparam int ERA_DAYS = 146097;
  localparam int ERA_YEARS = 400;

  // Day number result, relative to day zero of year 0 in the March-based
  // calendar; only differences between two results are used.
  typedef struct packed {
    logic              done;
    logic              sane;
    logic [DATE_W-1:0] packed_date;
    logic [DAYS_W-1:0] days;
  } date_res_t;

  // Days before the first of each month, counting from March.
  function automatic logic [8:0] month_offset(input logic [3:0] mar);
    logic [8:0] r;
    case (mar)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/daily_step_history_rollover_core.sv */
// ============================================================================
// daily_step_history_rollover_core: daily step count with date rollover
// Keeps a count baseline, an anchor date and a chain of daily totals that
// shifts by the day gap whenever the date moves on.
// ============================================================================
// Sequence: an accepted transaction passes S_CALC, S_DECIDE, S_SHIFT (only on
//   a rollover, for n shifts, n being the day gap held to 1..HISTORY_DAYS) and
//   S_OUT; the history chain shifts one slot per cycle.
// The next transaction is taken only once the result sits in the output
//   register; S_OUT holds while that register is full and not taken.
// Reset: synchronous, active low; clears history, baseline and anchor.
module daily_step_history_rollover_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] chip_count, [43:32] rtc_year, [47:44] rtc_month,
  // [52:48] rtc_day, [55:53] query_day
  input  logic [55:0] in_tdata,
  // [0] chip_ok, [1] date_valid
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] today_steps, [63:32] queried_steps, [88:64] anchor_out
  output logic [95:0] out_tdata,
  // [0] rolled_over
  output logic        out_tuser
);

  localparam int H  = dshr_pkg::HISTORY_DAYS;
  localparam int SW = dshr_pkg::STEP_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CALC   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Captured transaction.
  logic [SW-1:0] chip_r;
  logic          chip_ok_r;
  logic          date_valid_r;
  logic [11:0]   year_r;
  logic [3:0]    month_r;
  logic [4:0]    day_r;
  logic [2:0]    query_r;

  // Persistent state.
  logic [SW-1:0]               baseline_r, baseline_nxt;
  logic                        taken_r, taken_nxt;
  logic [dshr_pkg::DATE_W-1:0] anchor_r, anchor_nxt;
  logic [dshr_pkg::DAYS_W-1:0] anchor_days_r, anchor_days_nxt;
  logic                        rolled_r, rolled_nxt;
  logic [dshr_pkg::CNT_W-1:0]  shift_cnt_r, shift_cnt_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic [SW-1:0]               out_today_r;
  logic [SW-1:0]               out_queried_r;
  logic                        out_rolled_r;
  logic [dshr_pkg::DATE_W-1:0] out_anchor_r;

  logic                        in_acc;
  logic                        out_load;
  logic                        calc_go_r;
  dshr_pkg::date_res_t         date_res;

  logic [SW-1:0]               base_eff;
  logic                        date_ok;
  logic                        do_roll;
  logic [SW-1:0]               finished;
  logic signed [dshr_pkg::DAYS_W:0] gap;
  logic [dshr_pkg::CNT_W-1:0]  shift_n;
  logic [SW-1:0]               today;
  logic [SW-1:0]               sel_hist;
  logic [SW-1:0]               queried;

  logic                        cell0_take;
  logic [SW-1:0]               cell0_din;
  logic                        chain_shift;
  logic [SW-1:0]               hist [H];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Capture the input transaction.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chip_r       <= in_tdata[31:0];
      year_r       <= in_tdata[43:32];
      month_r      <= in_tdata[47:44];
      day_r        <= in_tdata[52:48];
      query_r      <= in_tdata[55:53];
      chip_ok_r    <= in_tuser[0];
      date_valid_r <= in_tuser[1];
    end
  end

  // Date check and day number from the captured date.
  dshr_day_calc u_day_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_go_r),
    .year  (year_r),
    .month (month_r),
    .day   (day_r),
    .res   (date_res)
  );

  // Start strobe for the day calculation: first cycle of S_CALC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_go_r <= 1'b0;
    end else begin
      calc_go_r <= in_acc;
    end
  end

  // Decision on the captured transaction.
  always_comb begin
    base_eff = (chip_ok_r && !taken_r) ? chip_r : baseline_r;
    date_ok  = date_valid_r && date_res.sane;
    do_roll  = date_ok && (anchor_r != '0) && (date_res.packed_date != anchor_r);
    finished = (chip_ok_r && chip_r >= base_eff) ? chip_r - base_eff : '0;
    gap = $signed({1'b0, date_res.days}) - $signed({1'b0, anchor_days_r});
    if (gap <= 0) begin
      shift_n = dshr_pkg::CNT_W'(1);
    end else if (gap >= (dshr_pkg::DAYS_W + 1)'(H)) begin
      shift_n = dshr_pkg::CNT_W'(H);
    end else begin
      shift_n = gap[dshr_pkg::CNT_W-1:0];
    end
  end

  // Result fields from the updated state.
  always_comb begin
    today = (chip_ok_r && chip_r >= baseline_r) ? chip_r - baseline_r : '0;
    sel_hist = '0;
    for (int i = 1; i < H; i++) begin
      if (32'(query_r) == i) begin
        sel_hist = hist[i];
      end
    end
    queried = (query_r == 3'd0) ? today : sel_hist;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Sequencer and state updates.
  always_comb begin
    state_nxt       = state_r;
    baseline_nxt    = baseline_r;
    taken_nxt       = taken_r;
    anchor_nxt      = anchor_r;
    anchor_days_nxt = anchor_days_r;
    rolled_nxt      = rolled_r;
    shift_cnt_nxt   = shift_cnt_r;
    cell0_take      = 1'b0;
    cell0_din       = '0;
    chain_shift     = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (date_res.done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        taken_nxt    = taken_r || chip_ok_r;
        baseline_nxt = base_eff;
        rolled_nxt   = do_roll;
        if (date_ok && anchor_r == '0) begin
          anchor_nxt      = date_res.packed_date;
          anchor_days_nxt = date_res.days;
        end
        if (do_roll) begin
          // The finished day enters slot zero, then the chain shifts by the gap.
          cell0_take      = 1'b1;
          cell0_din       = finished;
          shift_cnt_nxt   = shift_n;
          anchor_nxt      = date_res.packed_date;
          anchor_days_nxt = date_res.days;
          baseline_nxt    = chip_ok_r ? chip_r : '0;
          state_nxt       = S_SHIFT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SHIFT: begin
        chain_shift   = 1'b1;
        cell0_take    = 1'b1;
        shift_cnt_nxt = shift_cnt_r - dshr_pkg::CNT_W'(1);
        if (shift_cnt_r == dshr_pkg::CNT_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      baseline_r  <= '0;
      taken_r     <= 1'b0;
      anchor_r    <= '0;
      rolled_r    <= 1'b0;
      shift_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      baseline_r  <= baseline_nxt;
      taken_r     <= taken_nxt;
      anchor_r    <= anchor_nxt;
      rolled_r    <= rolled_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    anchor_days_r <= anchor_days_nxt;
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_today_r   <= today;
      out_queried_r <= queried;
      out_rolled_r  <= rolled_r;
      out_anchor_r  <= anchor_r;
    end
  end

  // History chain: slot zero takes the finished day or zero, the others
  // take their lower neighbor.
  for (genvar g = 0; g < H; g++) begin : g_hist
    if (g == 0) begin : g_head
      dshr_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (cell0_take),
        .din   (cell0_din),
        .dout  (hist[g])
      );
    end else begin : g_body
      dshr_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (chain_shift),
        .din   (hist[g-1]),
        .dout  (hist[g])
      );
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_anchor_r, out_queried_r, out_today_r};
  assign out_tuser  = out_rolled_r;

  // Assertions.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (shift_cnt_r != '0)) else $error("shift count ran out");

  a_roll_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rolled_r) |-> (out_anchor_r != '0))
    else $error("rollover reported with unknown anchor");

  a_head_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && rolled_r) |-> (hist[0] == '0))
    else $error("slot zero not cleared after rollover");

endmodule

/* rtl/dshr_cell.sv */
// ============================================================================
// dshr_cell: one slot of the daily history chain
// Holds one daily total and takes its neighbor's value when told to.
// ============================================================================
module dshr_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [dshr_pkg::STEP_W-1:0] din,
  output logic [dshr_pkg::STEP_W-1:0] dout
);

  logic [dshr_pkg::STEP_W-1:0] val_r;

  // Slot register; history resets to all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (take) begin
      val_r <= din;
    end
  end

  assign dout = val_r;

endmodule

/* rtl/dshr_day_calc.sv */
// ============================================================================
// dshr_day_calc: date check and civil day number
// Two-stage pipeline that checks a date, packs it as YYYYMMDD and converts it
// to a day number for gap arithmetic.
// ============================================================================
module dshr_day_calc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [11:0]          year,
  input  logic [3:0]           month,
  input  logic [4:0]           day,
  output dshr_pkg::date_res_t  res
);

  logic                          sane;
  logic [25:0]                   packed_wide;
  logic [3:0]                    mar;
  logic [11:0]                   yy;
  logic                          era_hi;
  logic [8:0]                    yoe;
  logic [8:0]                    doy;

  logic                          s1_v_r;
  logic                          s1_sane_r;
  logic [dshr_pkg::DATE_W-1:0]   s1_packed_r;
  logic                          s1_era_hi_r;
  logic [8:0]                    s1_yoe_r;
  logic [8:0]                    s1_doy_r;

  logic [1:0]                    cent;
  logic [17:0]                   doe;
  logic [dshr_pkg::DAYS_W-1:0]   era_base;

  logic                          res_done_r;
  logic                          res_sane_r;
  logic [dshr_pkg::DATE_W-1:0]   res_packed_r;
  logic [dshr_pkg::DAYS_W-1:0]   res_days_r;

  // Stage one: range check, packing, March-based year and day of year.
  always_comb begin
    sane = (year >= 12'(dshr_pkg::YEAR_MIN)) && (year <= 12'(dshr_pkg::YEAR_MAX)) &&
           (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0);
    packed_wide = 26'(year) * 26'd10000 + 26'(month) * 26'd100 + 26'(day);
    mar = (month > 4'd2) ? month - 4'd3 : month + 4'd9;
    yy = (month <= 4'd2) ? year - 12'd1 : year;
    // Years of interest lie in 1999..2100, so the era is 4 or 5.
    era_hi = (yy >= 12'(5 * dshr_pkg::ERA_YEARS));
    yoe = 9'(yy - (era_hi ? 12'(5 * dshr_pkg::ERA_YEARS) : 12'(4 * dshr_pkg::ERA_YEARS)));
    doy = dshr_pkg::month_offset(mar) + 9'(day) - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_sane_r   <= sane;
      s1_packed_r <= packed_wide[dshr_pkg::DATE_W-1:0];
      s1_era_hi_r <= era_hi;
      s1_yoe_r    <= yoe;
      s1_doy_r    <= doy;
    end
  end

  // Stage two: day of era and day number.
  always_comb begin
    if (s1_yoe_r >= 9'd300) begin
      cent = 2'd3;
    end else if (s1_yoe_r >= 9'd200) begin
      cent = 2'd2;
    end else if (s1_yoe_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doe = 18'(s1_yoe_r) * 18'd365 + 18'(s1_yoe_r >> 2) - 18'(cent) + 18'(s1_doy_r);
    era_base = s1_era_hi_r ? dshr_pkg::DAYS_W'(5 * dshr_pkg::ERA_DAYS)
                           : dshr_pkg::DAYS_W'(4 * dshr_pkg::ERA_DAYS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_done_r <= 1'b0;
    end else begin
      res_done_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      res_sane_r   <= s1_sane_r;
      res_packed_r <= s1_packed_r;
      res_days_r   <= era_base + dshr_pkg::DAYS_W'(doe);
    end
  end

  assign res = {res_done_r, res_sane_r, res_packed_r, res_days_r};

endmodule

/* verif/tb_daily_step_history_rollover_core.sv */
// ============================================================================
// tb_daily_step_history_rollover_core: self-checking bench for the step core
// Sends poll ticks with counts, clock dates and history queries. The ticks
// are first directed at the corner cases, then drawn at random along a moving
// calendar. A tracker class keeps its own copy of the baseline, anchor and
// history, predicts every result and compares it field by field.
// ============================================================================
module tb_daily_step_history_rollover_core;

  // One poll tick as the sender sees it.
  typedef struct {
    logic [31:0] chip_count;
    logic        chip_ok;
    logic        date_valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  query_day;
  } tick_t;

  // One result as the receiver sees it.
  typedef struct {
    logic [31:0]                 today;
    logic [31:0]                 queried;
    logic                        rolled;
    logic [dshr_pkg::DATE_W-1:0] anchor;
  } day_summary_t;

  // Keeps its own day history and predicts the summary of every tick.
  class step_history_tracker;
    logic [31:0]                 history [dshr_pkg::HISTORY_DAYS];
    logic [31:0]                 baseline;
    bit                          have_baseline;
    logic [dshr_pkg::DATE_W-1:0] anchor;
    day_summary_t                expected_summaries [$];
    int                          errors;

    function new();
      foreach (history[k]) history[k] = '0;
      baseline      = '0;
      have_baseline = 0;
      anchor        = '0;
      errors        = 0;
    endfunction

    // Day count of a YYYYMMDD date on a March-based calendar; only
    // differences between two such counts are used.
    function int day_number(logic [dshr_pkg::DATE_W-1:0] ymd);
      int y, m, d, yy, era, yoe, mp, doy, doe;
      y   = ymd / 10000;
      m   = (ymd / 100) % 100;
      d   = ymd % 100;
      yy  = (m <= 2) ? y - 1 : y;
      era = yy / dshr_pkg::ERA_YEARS;
      yoe = yy - era * dshr_pkg::ERA_YEARS;
      mp  = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * dshr_pkg::ERA_DAYS + doe;
    endfunction

    function logic [31:0] clamped_delta(logic [31:0] chip);
      return (chip >= baseline) ? chip - baseline : 32'd0;
    endfunction

    // Accepted tick: update the state and queue the summary it must give.
    function void note_tick(tick_t t);
      day_summary_t                s;
      logic [dshr_pkg::DATE_W-1:0] now;
      logic [31:0]                 finished;
      logic [31:0]                 shifted [dshr_pkg::HISTORY_DAYS];
      int                          gap;
      bit                          sane;
      s.rolled = 1'b0;
      if (t.chip_ok && !have_baseline) begin
        baseline      = t.chip_count;
        have_baseline = 1;
      end
      sane = t.date_valid && t.year >= dshr_pkg::YEAR_MIN && t.year <= dshr_pkg::YEAR_MAX &&
             t.month >= 1 && t.month <= 12 && t.day >= 1;
      if (sane) begin
        now = dshr_pkg::DATE_W'(t.year * 10000 + t.month * 100 + t.day);
        if (anchor == '0) begin
          anchor = now;
        end else if (now != anchor) begin
          finished = t.chip_ok ? clamped_delta(t.chip_count) : 32'd0;
          gap = day_number(now) - day_number(anchor);
          if (gap <= 0) gap = 1;
          if (gap >= dshr_pkg::HISTORY_DAYS) begin
            foreach (history[k]) history[k] = '0;
          end else begin
            foreach (shifted[k]) shifted[k] = '0;
            shifted[gap] = finished;
            for (int k = 1; k < dshr_pkg::HISTORY_DAYS - gap; k++) begin
              shifted[gap + k] = history[k];
            end
            history = shifted;
          end
          anchor   = now;
          baseline = t.chip_ok ? t.chip_count : 32'd0;
          s.rolled = 1'b1;
        end
      end
      s.today = t.chip_ok ? clamped_delta(t.chip_count) : 32'd0;
      if (t.query_day == 0) s.queried = s.today;
      else if (t.query_day < dshr_pkg::HISTORY_DAYS) s.queried = history[t.query_day];
      else s.queried = '0;
      s.anchor = anchor;
      expected_summaries.push_back(s);
    endfunction

    // Accepted result: compare with the oldest expected summary.
    function void check_summary(day_summary_t got);
      day_summary_t want;
      if (expected_summaries.size() == 0) begin
        $error("unexpected result transaction: today_steps %0d", got.today);
        errors++;
        return;
      end
      want = expected_summaries.pop_front();
      if (got.today !== want.today) begin
        $error("today_steps: expected %0d, actual %0d", want.today, got.today);
        errors++;
      end
      if (got.queried !== want.queried) begin
        $error("queried_steps: expected %0d, actual %0d", want.queried, got.queried);
        errors++;
      end
      if (got.rolled !== want.rolled) begin
        $error("rolled_over: expected %0b, actual %0b", want.rolled, got.rolled);
        errors++;
      end
      if (got.anchor !== want.anchor) begin
        $error("anchor_out: expected %0d, actual %0d", want.anchor, got.anchor);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tuser;

  step_history_tracker tracker = new();
  bit          calm;
  int          cycle_count;

  // Calendar walked by the random ticks, and the running chip count.
  int          cur_y, cur_m, cur_d;
  logic [31:0] chip_run;

  daily_step_history_rollover_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("[daily_step_history_rollover_core] ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_tready  = 1'b0;
    cycle_count = 0;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count >= 2000 && cycle_count < 2300) out_tready = 1'b0;
      else if (calm) out_tready = 1'b1;
      else out_tready = ($urandom_range(0, 99) >= 13);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    day_summary_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.today   = out_tdata[31:0];
      got.queried = out_tdata[63:32];
      got.anchor  = out_tdata[64 +: dshr_pkg::DATE_W];
      got.rolled  = out_tuser;
      tracker.check_summary(got);
    end
  end

  function automatic tick_t mk_tick(logic [31:0] count, logic ok, logic dv,
                                    int y, int m, int d, int q);
    tick_t t;
    t.chip_count = count;
    t.chip_ok    = ok;
    t.date_valid = dv;
    t.year       = 12'(y);
    t.month      = 4'(m);
    t.day        = 5'(d);
    t.query_day  = 3'(q);
    return t;
  endfunction

  function automatic int days_in_month(int y, int m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Move the walked calendar forward, wrapping past the last sane year.
  task automatic advance_days(int n);
    repeat (n) begin
      cur_d++;
      if (cur_d > days_in_month(cur_y, cur_m)) begin
        cur_d = 1;
        cur_m++;
        if (cur_m > 12) begin
          cur_m = 1;
          cur_y = (cur_y >= dshr_pkg::YEAR_MAX) ? dshr_pkg::YEAR_MIN : cur_y + 1;
        end
      end
    end
  endtask

  // Random tick: mostly a plausible day-by-day walk, some noise.
  task automatic random_tick(output tick_t t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) chip_run = $urandom();
    else chip_run = chip_run + $urandom_range(0, 3000);
    t.chip_count = ($urandom_range(0, 99) < 5) ? $urandom() : chip_run;
    t.chip_ok    = ($urandom_range(0, 99) < 85);
    t.date_valid = 1'b1;
    t.query_day  = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (r >= 55 && r < 67) advance_days($urandom_range(1, 2));
      else if (r >= 67) advance_days($urandom_range(3, 9));
    end else if (r < 78) begin
      // Jump anywhere in the sane range, often backwards.
      cur_y = $urandom_range(dshr_pkg::YEAR_MIN, dshr_pkg::YEAR_MAX);
      cur_m = $urandom_range(1, 12);
      cur_d = $urandom_range(1, days_in_month(cur_y, cur_m));
    end
    t.year  = 12'(cur_y);
    t.month = 4'(cur_m);
    t.day   = 5'(cur_d);
    if (r >= 78 && r < 84) begin
      // Day near or past the end of the month.
      t.day = 5'($urandom_range(28, 31));
    end else if (r >= 84 && r < 91) begin
      t.date_valid = 1'b0;
      t.year       = 12'($urandom_range(0, 4095));
      t.month      = 4'($urandom_range(0, 15));
      t.day        = 5'($urandom_range(0, 31));
    end else if (r >= 91) begin
      t.date_valid = 1'($urandom_range(0, 1));
      t.year       = 12'($urandom_range(0, 4095));
      t.month      = 4'($urandom_range(0, 15));
      t.day        = 5'($urandom_range(0, 31));
    end
  endtask

  // Offer one tick and hold it until accepted; starts and ends at a falling edge.
  task automatic send_tick(tick_t t);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {t.query_day, t.day, t.month, t.year, t.chip_count};
    in_tuser  = {t.date_valid, t.chip_ok};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_tick(t);
    @(negedge clk);
  endtask

  // Main sequence.
  initial begin
    tick_t t;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    calm      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: no baseline yet, then the first good count.
    send_tick(mk_tick(32'd500, 1'b0, 1'b0, 2000, 1, 1, 0));
    send_tick(mk_tick(32'd1000, 1'b1, 1'b0, 2000, 1, 1, 0));
    // Insane dates are ignored.
    send_tick(mk_tick(32'd1100, 1'b1, 1'b1, 1999, 6, 15, 1));
    send_tick(mk_tick(32'd1100, 1'b1, 1'b1, 2101, 6, 15, 0));
    send_tick(mk_tick(32'd1100, 1'b1, 1'b1, 2050, 0, 15, 0));
    send_tick(mk_tick(32'd1100, 1'b1, 1'b1, 2050, 13, 15, 0));
    send_tick(mk_tick(32'd1100, 1'b1, 1'b1, 2050, 6, 0, 0));
    // First sane date sets the anchor; count below baseline clamps to zero.
    send_tick(mk_tick(32'd1500, 1'b1, 1'b1, 2000, 1, 1, 0));
    send_tick(mk_tick(32'd900, 1'b1, 1'b1, 2000, 1, 1, 0));
    // Next day rolls over.
    send_tick(mk_tick(32'd4000, 1'b1, 1'b1, 2000, 1, 2, 1));
    send_tick(mk_tick(32'd4500, 1'b1, 1'b1, 2000, 1, 2, 1));
    // Long gap clears the history; then Feb 31 counts as Mar 2 with a failed read.
    send_tick(mk_tick(32'd6000, 1'b1, 1'b1, 2000, 2, 29, 1));
    send_tick(mk_tick(32'd7000, 1'b0, 1'b1, 2000, 2, 31, 2));
    send_tick(mk_tick(32'd7000, 1'b1, 1'b1, 2000, 2, 31, 2));
    // Clock going back counts as one day.
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 2000, 2, 28, 1));
    for (int q = 2; q < 8; q++) send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 2000, 2, 28, q));
    send_tick(mk_tick(32'd0, 1'b1, 1'b1, 2100, 12, 31, 3));
    send_tick(mk_tick(32'd250, 1'b1, 1'b1, 2100, 12, 30, 1));
    send_tick(mk_tick(32'd0, 1'b0, 1'b1, 2000, 1, 1, 0));

    // Random walk along the calendar.
    cur_y    = $urandom_range(dshr_pkg::YEAR_MIN, dshr_pkg::YEAR_MAX);
    cur_m    = $urandom_range(1, 12);
    cur_d    = $urandom_range(1, days_in_month(cur_y, cur_m));
    chip_run = $urandom_range(0, 100000);
    for (int i = 0; i < 1100; i++) begin
      calm = (i >= 500 && i < 650);
      random_tick(t);
      send_tick(t);
    end
    calm      = 1'b0;
    in_tvalid = 1'b0;

    // Drain, then allow for a late rollover shift.
    while (tracker.expected_summaries.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.expected_summaries.size() != 0) begin
      $error("%0d expected results never arrived", tracker.expected_summaries.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("[daily_step_history_rollover_core] OK");
    end else begin
      $display("[daily_step_history_rollover_core] ERROR");
    end
    $finish;
  end

endmodule

/* daily_step_history_rollover_core.f */
rtl/dshr_pkg.sv
rtl/dshr_cell.sv
rtl/dshr_day_calc.sv
rtl/daily_step_history_rollover_core.sv
verif/tb_daily_step_history_rollover_core.sv
